[rtl/bpfa_pkg.sv]
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

	localparam int unsigned MAX_FRAMES_DEF = 65536;
	localparam int unsigned PAGE_SHIFT     = 12;
	localparam int unsigned CNT_W          = 17;
	localparam int unsigned ADDR_W         = 28;
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;
	localparam logic [CNT_W-1:0] FC_RESET  = CNT_W'(65536);

	typedef enum logic [1:0] {
		FN_ALLOC = 2'd0,
		FN_FREE  = 2'd1,
		FN_RSV   = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		STS_OK   = 2'd0,
		STS_FAIL = 2'd1,
		STS_IGN  = 2'd2
	} status_t;

	typedef enum logic {
		REG_FRAME_COUNT  = 1'b0,
		REG_TOTAL_FRAMES = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ARD,
		S_ACHK,
		S_ABITS,
		S_MRD,
		S_MWR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [ADDR_W-1:0] phys_addr;
		logic [CNT_W-1:0]  page_count;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] base_addr;
		logic [CNT_W-1:0]  free_frames;
		logic [CNT_W-1:0]  used_frames;
	} rsp_t;

endpackage

[rtl/bitmap_page_frame_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit page frame allocator over a one-bit-per-frame used map.
// ----------------------------------------------------------------------------
// After reset the block sweeps the used map to all ones, one word a cycle,
// and holds busy meanwhile. A request is taken when start is high and busy
// low; the result appears for one cycle with done and cannot be held off.
// The map RAM has one read and one write port. Free and reserve read each map
// word they touch (S_MRD) and then write it back (S_MWR), and the result is
// shown in S_DONE; allocate reads each word it scans (S_ARD), checks it
// (S_ACHK), walks a partly used word eight frames at a time (S_ABITS), and
// marks the run it finds through the same read and write states.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator
	import bpfa_pkg::*;
#(
	parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	output logic             done,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [CNT_W-1:0] cfg_data
);

	localparam int unsigned MAP_WORDS = (MAX_FRAMES + 63) / 64;
	localparam int unsigned WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned FW = $clog2(MAX_FRAMES + 1);
	localparam int unsigned RW = ((FW > CNT_W) ? FW : CNT_W) + 1;
	localparam logic [RW-1:0] MAXF = RW'(MAX_FRAMES);
	localparam logic [WW-1:0] LAST_WORD = WW'(MAP_WORDS - 1);

	state_t state_q, state_d;

	logic [CNT_W-1:0] fc_q, tf_q;
	logic [CNT_W-1:0] free_q, free_d;
	logic [WW-1:0]    w_q, w_d;
	logic [2:0]       k_q, k_d;
	logic [RW-1:0]    run_q, run_d, start_q, start_d;
	logic [RW-1:0]    lo_q, lo_d, hi_q, hi_d;
	logic [RW-1:0]    n_q, n_d;
	logic             set_q, set_d;
	logic [63:0]      word_q, word_d;
	logic [1:0]       status_q, status_d;
	logic [ADDR_W-1:0] base_q, base_d;

	logic          ram_we, ram_rd;
	logic [WW-1:0] ram_waddr, ram_raddr;
	logic [63:0]   ram_wdata, ram_rdata;

	logic [63:0]   rmw_wdata;
	logic [6:0]    rmw_count;

	logic [RW-1:0] limit, lim_m1, first, req_n, range_end, hi_m1, wbase;
	logic [WW-1:0] scan_last, hi_last;
	logic [63:0]   inv_mask, masked;

	assign cfg_ready = 1'b1;

	assign limit     = ({1'b0, fc_q} < MAXF) ? RW'(fc_q) : MAXF;
	assign lim_m1    = limit - RW'(1);
	assign scan_last = lim_m1[6 +: WW];
	assign hi_m1     = hi_q - RW'(1);
	assign hi_last   = hi_m1[6 +: WW];
	assign wbase     = {(RW-6-WW)'(0), w_q, 6'd0};
	assign first     = RW'(req.phys_addr[ADDR_W-1:PAGE_SHIFT]);
	assign req_n     = RW'(req.page_count);
	assign range_end = ((first + req_n) > limit) ? limit : (first + req_n);

	// frames at or past the limit look used to the scan
	assign inv_mask = (w_q == scan_last && limit[5:0] != 6'd0)
		? ({64{1'b1}} << limit[5:0]) : 64'd0;
	assign masked   = ram_rdata | inv_mask;

	bpfa_ram #(.WIDTH(64), .DEPTH(MAP_WORDS), .AW(WW)) u_map (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_waddr),
		.wdata   (ram_wdata),
		.rd_en   (ram_rd),
		.rd_addr (ram_raddr),
		.rdata   (ram_rdata)
	);

	bpfa_rmw #(.WW(WW), .RW(RW)) u_rmw (
		.data  (ram_rdata),
		.word  (w_q),
		.lo    (lo_q),
		.hi    (hi_q),
		.set   (set_q),
		.wdata (rmw_wdata),
		.count (rmw_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			fc_q    <= FC_RESET;
			tf_q    <= '0;
			free_q  <= '0;
			w_q     <= '0;
		end else begin
			state_q <= state_d;
			free_q  <= free_d;
			w_q     <= w_d;
			if (cfg_valid && cfg_ready) begin
				unique case (reg_idx_t'(cfg_index))
					REG_FRAME_COUNT:  fc_q <= cfg_data;
					REG_TOTAL_FRAMES: tf_q <= cfg_data;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		k_q      <= k_d;
		run_q    <= run_d;
		start_q  <= start_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		n_q      <= n_d;
		set_q    <= set_d;
		word_q   <= word_d;
		status_q <= status_d;
		base_q   <= base_d;
	end

	always_comb begin
		logic          found;
		logic [RW-1:0] run_v, st_v, fst_v, sum64, frame_v;
		logic [RW:0]   fsum;

		state_d  = state_q;
		free_d   = free_q;
		w_d      = w_q;
		k_d      = k_q;
		run_d    = run_q;
		start_d  = start_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		n_d      = n_q;
		set_d    = set_q;
		word_d   = word_q;
		status_d = status_q;
		base_d   = base_q;
		ram_we    = 1'b0;
		ram_waddr = w_q;
		ram_wdata = rmw_wdata;
		ram_rd    = 1'b0;
		ram_raddr = w_q;
		found   = 1'b0;
		run_v   = run_q;
		st_v    = start_q;
		fst_v   = start_q;
		frame_v = '0;
		sum64   = run_q + RW'(64);
		fsum    = '0;

		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = '1;
				if (w_q == LAST_WORD) begin
					w_d     = '0;
					state_d = S_IDLE;
				end else begin
					w_d = w_q + WW'(1);
				end
			end
			S_IDLE: begin
				if (start) begin
					base_d   = '0;
					status_d = STS_OK;
					n_d      = req_n;
					unique case (req.func)
						FN_ALLOC: begin
							if (req_n == '0 || limit == '0) begin
								status_d = STS_FAIL;
								state_d  = S_DONE;
							end else begin
								w_d     = '0;
								run_d   = '0;
								state_d = S_ARD;
							end
						end
						FN_FREE, FN_RSV: begin
							if (req_n == '0 || (req.func == FN_FREE && req.phys_addr == '0)) begin
								status_d = STS_IGN;
								state_d  = S_DONE;
							end else if (range_end <= first) begin
								state_d = S_DONE;
							end else begin
								lo_d    = first;
								hi_d    = range_end;
								set_d   = (req.func == FN_RSV);
								w_d     = first[6 +: WW];
								state_d = S_MRD;
							end
						end
						default: begin
							status_d = STS_IGN;
							state_d  = S_DONE;
						end
					endcase
				end
			end
			S_ARD: begin
				ram_rd  = 1'b1;
				state_d = S_ACHK;
			end
			S_ACHK: begin
				if (&masked) begin
					run_v = '0;
				end else if (masked == '0) begin
					st_v = (run_q == '0) ? wbase : start_q;
					if (sum64 >= n_q) begin
						found = 1'b1;
						fst_v = st_v;
					end
					run_v = sum64;
				end else begin
					word_d  = masked;
					k_d     = '0;
					state_d = S_ABITS;
				end
				run_d   = run_v;
				start_d = st_v;
				if (state_d != S_ABITS && !found) begin
					if (w_q == scan_last) begin
						status_d = STS_FAIL;
						state_d  = S_DONE;
					end else begin
						w_d     = w_q + WW'(1);
						state_d = S_ARD;
					end
				end
			end
			S_ABITS: begin
				// eight frames of the held word per cycle
				for (int b = 0; b < 8; b++) begin
					frame_v = wbase + RW'({k_q, 3'(b)});
					if (!found) begin
						if (word_q[{k_q, 3'(b)}]) begin
							run_v = '0;
						end else begin
							if (run_v == '0) begin
								st_v = frame_v;
							end
							run_v = run_v + RW'(1);
							if (run_v == n_q) begin
								found = 1'b1;
								fst_v = st_v;
							end
						end
					end
				end
				run_d   = run_v;
				start_d = st_v;
				if (!found) begin
					if (k_q != 3'd7) begin
						k_d = k_q + 3'd1;
					end else if (w_q == scan_last) begin
						status_d = STS_FAIL;
						state_d  = S_DONE;
					end else begin
						w_d     = w_q + WW'(1);
						state_d = S_ARD;
					end
				end
			end
			S_MRD: begin
				ram_rd  = 1'b1;
				state_d = S_MWR;
			end
			S_MWR: begin
				ram_we = 1'b1;
				if (set_q) begin
					free_d = (free_q > CNT_W'(rmw_count)) ? free_q - CNT_W'(rmw_count) : '0;
				end else begin
					fsum   = (RW+1)'(free_q) + (RW+1)'(rmw_count);
					free_d = (fsum > (RW+1)'(CNT_MAX)) ? CNT_MAX : fsum[CNT_W-1:0];
				end
				if (w_q == hi_last) begin
					state_d = S_DONE;
				end else begin
					w_d     = w_q + WW'(1);
					state_d = S_MRD;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// run found: mark it used through the reserve path
		if (found && (state_q == S_ACHK || state_q == S_ABITS)) begin
			lo_d    = fst_v;
			hi_d    = fst_v + n_q;
			set_d   = 1'b1;
			w_d     = fst_v[6 +: WW];
			base_d  = ADDR_W'({fst_v, {PAGE_SHIFT{1'b0}}});
			state_d = S_MRD;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	assign rsp.status      = status_q;
	assign rsp.base_addr   = base_q;
	assign rsp.free_frames = free_q;
	assign rsp.used_frames = (tf_q > free_q) ? tf_q - free_q : '0;

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
	a_base_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != STS_OK |-> rsp.base_addr == '0)
		else $error("base address set on a failed or ignored request");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");
`endif

endmodule

[rtl/bpfa_ram.sv]
// ----------------------------------------------------------------------------
// bpfa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpfa_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/bpfa_rmw.sv]
// ----------------------------------------------------------------------------
// bpfa_rmw
// Word update unit: masks one map word to a frame range, sets or clears
// the bits and counts how many changed.
// ----------------------------------------------------------------------------
module bpfa_rmw #(
	parameter int unsigned WW = 10,
	parameter int unsigned RW = 18
) (
	input  logic [63:0]   data,
	input  logic [WW-1:0] word,
	input  logic [RW-1:0] lo,
	input  logic [RW-1:0] hi,
	input  logic          set,
	output logic [63:0]   wdata,
	output logic [6:0]    count
);

	logic [RW-1:0] hi_m1;
	logic [63:0]   mask;
	logic [63:0]   changed;

	assign hi_m1 = hi - RW'(1);

	always_comb begin
		mask = '1;
		if (word == lo[6 +: WW]) begin
			mask = mask & ({64{1'b1}} << lo[5:0]);
		end
		if (word == hi_m1[6 +: WW]) begin
			mask = mask & ({64{1'b1}} >> (6'd63 - hi_m1[5:0]));
		end
		changed = set ? (~data & mask) : (data & mask);
		wdata   = set ? (data | mask) : (data & ~mask);
		count   = '0;
		for (int b = 0; b < 64; b++) begin
			count = count + 7'(changed[b]);
		end
	end

endmodule

[bench/tb_bitmap_page_frame_allocator.sv]
// ----------------------------------------------------------------------------
// tb_bitmap_page_frame_allocator
// Self-checking bench for the first-fit page frame allocator: a directed pass
// over the corner cases and then random allocate, free and reserve traffic
// under several frame limits, each result checked against a local model of
// the used map and the free count.
// ----------------------------------------------------------------------------
module tb_bitmap_page_frame_allocator;
	import bpfa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NFRAMES  = 65536;
	localparam int unsigned MAP_W    = NFRAMES / 64;
	localparam longint      CYC_LIMIT = 64'd20000000;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             req;
	logic             done;
	rsp_t             rsp;
	logic             cfg_valid;
	logic             cfg_ready;
	logic             cfg_index;
	logic [CNT_W-1:0] cfg_data;

	bitmap_page_frame_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// local copy of the allocator state
	logic [63:0]      frame_used [MAP_W];
	logic [CNT_W-1:0] free_cnt;
	logic [CNT_W-1:0] lim_reg;
	logic [CNT_W-1:0] total_reg;

	req_t   pending_reqs[$];
	rsp_t   expected_rsps[$];
	int     errors;
	longint cycles;
	bit     quiet_tail;
	bit     feed_done;
	int     gap_left;
	bit     took;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic bit frame_is_used(input int unsigned f);
		return frame_used[(f >> 6) % MAP_W][f & 63];
	endfunction

	// computes the response of one request and updates the local state
	function automatic rsp_t serve_request(input req_t r);
		rsp_t             o;
		int unsigned      lim, n, run, first_f, f, e;
		logic [27:0]      addr;
		lim = (lim_reg > NFRAMES) ? NFRAMES : lim_reg;
		n = r.page_count;
		addr = r.phys_addr;
		o = '0;
		o.status = STS_IGN;
		if (r.func == FN_ALLOC) begin
			o.status = STS_FAIL;
			run = 0;
			first_f = 0;
			if (n != 0) begin
				for (f = 0; f < lim; f++) begin
					if (frame_is_used(f)) begin
						run = 0;
					end else begin
						if (run == 0) first_f = f;
						run++;
						if (run == n) begin
							for (e = first_f; e < first_f + n; e++)
								frame_used[e >> 6][e & 63] = 1'b1;
							free_cnt = (free_cnt > n) ? free_cnt - CNT_W'(n) : '0;
							o.base_addr = 28'(first_f << PAGE_SHIFT);
							o.status = STS_OK;
							break;
						end
					end
				end
			end
		end else if (r.func == FN_FREE || r.func == FN_RSV) begin
			if (n == 0 || (r.func == FN_FREE && addr == 0)) begin
				o.status = STS_IGN;
			end else begin
				o.status = STS_OK;
				first_f = addr >> PAGE_SHIFT;
				e = first_f + n;
				if (e > lim) e = lim;
				for (f = first_f; f < e; f++) begin
					if (r.func == FN_FREE && frame_is_used(f)) begin
						frame_used[(f >> 6) % MAP_W][f & 63] = 1'b0;
						if (free_cnt != CNT_MAX) free_cnt++;
					end else if (r.func == FN_RSV && !frame_is_used(f)) begin
						frame_used[(f >> 6) % MAP_W][f & 63] = 1'b1;
						if (free_cnt != 0) free_cnt--;
					end
				end
			end
		end
		o.free_frames = free_cnt;
		o.used_frames = (total_reg > free_cnt) ? total_reg - free_cnt : '0;
		return o;
	endfunction

	// request beat taken at this edge: predict its result
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			expected_rsps.push_back(serve_request(req));
			took <= 1'b1;
		end else begin
			took <= 1'b0;
		end
	end

	// driver: one beat per accepted start, random gap bursts between items
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			gap_left <= 0;
		end else if (took) begin
			// accepted at the last rising edge
			if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				gap_left <= $urandom_range(1, 8) - 1;
			end else if (pending_reqs.size() != 0) begin
				req <= pending_reqs.pop_front();
			end else begin
				start <= 1'b0;
			end
		end else if (!start) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_reqs.size() != 0 && feed_done == 1'b0) begin
				start <= 1'b1;
				req <= pending_reqs.pop_front();
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				report("unexpected result", 32'(rsp.status), 32'hffffffff);
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.status !== want.status)
					report("status", 32'(rsp.status), 32'(want.status));
				if (rsp.base_addr !== want.base_addr)
					report("base_addr", 32'(rsp.base_addr), 32'(want.base_addr));
				if (rsp.free_frames !== want.free_frames)
					report("free_frames", 32'(rsp.free_frames), 32'(want.free_frames));
				if (rsp.used_frames !== want.used_frames)
					report("used_frames", 32'(rsp.used_frames), 32'(want.used_frames));
			end
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CNT_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_FRAME_COUNT) lim_reg = val;
		else total_reg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic req_t make_req(input func_t fn, input int unsigned frame,
			input int unsigned n);
		req_t r;
		r.func = fn;
		r.phys_addr = 28'(frame << PAGE_SHIFT) | 28'($urandom_range(0, 4095));
		r.page_count = CNT_W'(n);
		return r;
	endfunction

	// random traffic over a window of frames, mostly small sizes
	task automatic add_random(input int count, input int unsigned span);
		req_t r;
		int   k, sel;
		for (k = 0; k < count; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) r = make_req(FN_ALLOC, 0, $urandom_range(1, 40));
			else if (sel < 70) r = make_req(FN_FREE, $urandom_range(0, span), $urandom_range(1, 80));
			else if (sel < 90) r = make_req(FN_RSV, $urandom_range(0, span), $urandom_range(1, 60));
			else begin
				r.func = $urandom_range(0, 3);
				r.phys_addr = $urandom();
				r.page_count = (sel < 94) ? CNT_W'($urandom()) : CNT_W'($urandom_range(0, 3));
			end
			pending_reqs.push_back(r);
		end
	endtask

	initial begin
		int ph;
		clk = 1'b0;
		errors = 0;
		cycles = 0;
		quiet_tail = 1'b0;
		feed_done = 1'b1;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_FRAME_COUNT;
		cfg_data = '0;
		lim_reg = FC_RESET;
		total_reg = '0;
		free_cnt = '0;
		for (int w = 0; w < MAP_W; w++) frame_used[w] = '1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corners under the default limit
		write_reg(REG_TOTAL_FRAMES, CNT_W'(65536));
		pending_reqs.push_back(make_req(FN_ALLOC, 0, 1));        // nothing free yet
		pending_reqs.push_back(make_req(FN_ALLOC, 0, 0));        // zero length
		pending_reqs.push_back('{func: FN_FREE, phys_addr: '0, page_count: CNT_W'(5)});
		pending_reqs.push_back(make_req(FN_FREE, 1, 0));         // zero length ignored
		pending_reqs.push_back(make_req(FN_RSV, 1, 0));
		pending_reqs.push_back(make_req(FN_FREE, 1, 200));
		pending_reqs.push_back(make_req(FN_ALLOC, 0, 64));
		pending_reqs.push_back(make_req(FN_ALLOC, 0, 300));      // no run
		pending_reqs.push_back(make_req(FN_RSV, 0, 100));
		pending_reqs.push_back(make_req(FN_FREE, 65500, 131071)); // past the limit
		pending_reqs.push_back(make_req(FN_FREE, 65535, 1));
		pending_reqs.push_back(make_req(FN_ALLOC, 0, 37));
		pending_reqs.push_back(make_req(FN_ALLOC, 0, 65536));
		pending_reqs.push_back('{func: 2'd3, phys_addr: '1, page_count: '1});
		pending_reqs.push_back('{func: FN_FREE, phys_addr: '1, page_count: '1});
		pending_reqs.push_back(make_req(FN_FREE, 1, 131071));    // free all frames from 1 up
		pending_reqs.push_back(make_req(FN_ALLOC, 0, 65535));
		pending_reqs.push_back(make_req(FN_RSV, 0, 131071));     // count stays at zero
		pending_reqs.push_back(make_req(FN_FREE, 4, 1000));
		pending_reqs.push_back(make_req(FN_ALLOC, 0, 1000));
		feed_done = 1'b0;
		wait_drained();

		for (ph = 0; ph < 5; ph++) begin
			feed_done = 1'b1;
			case (ph)
				0: begin write_reg(REG_FRAME_COUNT, '0); write_reg(REG_TOTAL_FRAMES, '1); end
				1: begin write_reg(REG_FRAME_COUNT, CNT_W'(1)); write_reg(REG_TOTAL_FRAMES, '0); end
				2: begin write_reg(REG_FRAME_COUNT, '1); write_reg(REG_TOTAL_FRAMES, CNT_W'(300)); end
				3: begin write_reg(REG_FRAME_COUNT, CNT_W'(700)); write_reg(REG_TOTAL_FRAMES, CNT_W'(700)); end
				default: begin
					write_reg(REG_FRAME_COUNT, CNT_W'(256));
					write_reg(REG_TOTAL_FRAMES, CNT_W'($urandom_range(0, 131071)));
				end
			endcase
			// keep allocation scans short: mostly the low part of the map is free
			pending_reqs.push_back(make_req(FN_RSV, 0, 131071));
			pending_reqs.push_back(make_req(FN_FREE, 1, 600));
			add_random((ph < 2) ? 60 : 130, 700);
			if (ph == 4) quiet_tail = 1'b1;
			feed_done = 1'b0;
			// sender holds off until everything has come back
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
